// ----- hw/rtl/pstk_pkg.sv -----
// Shared types and constants of the priority-sorted keyed table.
package pstk_pkg;

  // Operation codes carried in the input tuser.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  // Status codes carried in the output tuser.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_MISS = 2'd3;

  // Field widths of the stream items.
  localparam int unsigned OP_W     = 2;
  localparam int unsigned KEY_W    = 8;
  localparam int unsigned PRIO_W   = 16;
  localparam int unsigned POLICY_W = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned COUNT_W  = 5;

  // Packed stream widths, rounded up to whole bytes.
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 40;

  // Result of comparing one stored entry against the item being processed.
  typedef struct packed {
    logic key_eq;
    logic prio_gt;
  } cmp_res_t;

endpackage

// ----- hw/rtl/pstk_mem.sv -----
// Entry storage of the table: one write port and one registered read port.
module pstk_mem
  import pstk_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write first-port, read second-port; read data is registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/pstk_cmp.sv -----
// Shared compare unit: matches a stored entry against the current key and priority.
module pstk_cmp
  import pstk_pkg::*;
#(
  parameter int unsigned KEY_BITS  = 8,
  parameter int unsigned PRIO_BITS = 16
) (
  input  logic [KEY_BITS-1:0]  ent_key,
  input  logic [PRIO_BITS-1:0] ent_prio,
  input  logic [KEY_BITS-1:0]  ref_key,
  input  logic [PRIO_BITS-1:0] ref_prio,
  output cmp_res_t             res
);

  // Key equality finds duplicates and targets; strictly greater priority finds the slot.
  always_comb begin
    res.key_eq  = (ent_key == ref_key);
    res.prio_gt = (ent_prio > ref_prio);
  end

endmodule

// ----- hw/rtl/priority_sorted_keyed_table.sv -----
// Order of work: a scan compares every stored entry, then the result is loaded once the output
// register is free; an insert adds a placement step, plus a shift-up walk when it moves entries,
// and a delete that moves entries adds a shift-down walk.
// Throughput: one item at a time; in_tready returns the cycle after the result is loaded, and
// the single read port of the entry memory sets the walk length.
// Reset clears the entry count and the handshake state; slots above the count are never read.
module priority_sorted_keyed_table
  import pstk_pkg::*;
#(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned KEY_BITS  = 8,
  parameter int unsigned PRIO_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input item.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // key_id[7:0], prio[23:8], policy_tag[31:24]
  input  logic [OP_W-1:0]        in_tuser,   // op[1:0]
  // Result item.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // position[3:0], found_prio[19:4],
                                             // found_policy[27:20], count[32:28], zeros above
  output logic [STATUS_W-1:0]    out_tuser   // status[1:0]
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = KEY_BITS + PRIO_BITS + POLICY_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHUP,
    S_SHDN,
    S_PUT,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // Control registers.
  logic          out_valid_r, out_valid_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic [IW-1:0] pend_idx_r, pend_idx_nxt;
  logic          iss_done_r, iss_done_nxt;
  logic          hit_r, hit_nxt;
  logic          gt_found_r, gt_found_nxt;

  // Payload registers.
  logic [OP_W-1:0]      op_r, op_nxt;
  logic [KEY_BITS-1:0]  key_r, key_nxt;
  logic [PRIO_BITS-1:0] prio_r, prio_nxt;
  logic [POLICY_W-1:0]  tag_r, tag_nxt;
  logic [IW-1:0]        hit_idx_r, hit_idx_nxt;
  logic [PRIO_BITS-1:0] hit_prio_r, hit_prio_nxt;
  logic [POLICY_W-1:0]  hit_pol_r, hit_pol_nxt;
  logic [IW-1:0]        ins_idx_r, ins_idx_nxt;
  logic [STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic [IW-1:0]        res_pos_r, res_pos_nxt;
  logic [PRIO_BITS-1:0] res_prio_r, res_prio_nxt;
  logic [POLICY_W-1:0]  res_pol_r, res_pol_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [STATUS_W-1:0]  out_user_r, out_user_nxt;

  // Memory port signals.
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [IW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;

  logic [KEY_BITS-1:0]  rd_key;
  logic [PRIO_BITS-1:0] rd_prio;
  logic [POLICY_W-1:0]  rd_pol;
  cmp_res_t             cmp;

  logic          in_fire;
  logic          scan_done;
  logic [CW-1:0] del_src;

  pstk_mem #(
    .DEPTH (DEPTH),
    .WIDTH (EW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Stored entries are packed as policy, priority, key from the top down.
  assign rd_key  = mem_rdata[KEY_BITS-1:0];
  assign rd_prio = mem_rdata[KEY_BITS +: PRIO_BITS];
  assign rd_pol  = mem_rdata[KEY_BITS+PRIO_BITS +: POLICY_W];

  pstk_cmp #(
    .KEY_BITS  (KEY_BITS),
    .PRIO_BITS (PRIO_BITS)
  ) u_cmp (
    .ent_key  (rd_key),
    .ent_prio (rd_prio),
    .ref_key  (key_r),
    .ref_prio (prio_r),
    .res      (cmp)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign scan_done  = (rd_idx_r == cnt_r) && !rd_pend_r;
  assign del_src    = CW'(hit_idx_r) + CW'(1);

  // Sequencer: scan, shift and write steps over the memory's one read and one write port.
  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    cnt_nxt        = cnt_r;
    rd_idx_nxt     = rd_idx_r;
    rd_pend_nxt    = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    iss_done_nxt   = iss_done_r;
    hit_nxt        = hit_r;
    gt_found_nxt   = gt_found_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    prio_nxt       = prio_r;
    tag_nxt        = tag_r;
    hit_idx_nxt    = hit_idx_r;
    hit_prio_nxt   = hit_prio_r;
    hit_pol_nxt    = hit_pol_r;
    ins_idx_nxt    = ins_idx_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    res_prio_nxt   = res_prio_r;
    res_pol_nxt    = res_pol_r;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_raddr      = rd_idx_r[IW-1:0];

    // The result register empties when the item is taken.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt       = in_tuser;
          key_nxt      = KEY_BITS'(in_tdata[KEY_W-1:0]);
          prio_nxt     = PRIO_BITS'(in_tdata[KEY_W +: PRIO_W]);
          tag_nxt      = in_tdata[KEY_W+PRIO_W +: POLICY_W];
          rd_idx_nxt   = '0;
          hit_nxt      = 1'b0;
          gt_found_nxt = 1'b0;
          state_nxt    = S_SCAN;
        end
      end

      S_SCAN: begin
        // Issue the next read while slots remain.
        if (rd_idx_r < cnt_r) begin
          rd_pend_nxt  = 1'b1;
          pend_idx_nxt = rd_idx_r[IW-1:0];
          rd_idx_nxt   = rd_idx_r + CW'(1);
        end
        // Consume the read issued in the previous cycle.
        if (rd_pend_r) begin
          if (cmp.key_eq && !hit_r) begin
            hit_nxt      = 1'b1;
            hit_idx_nxt  = pend_idx_r;
            hit_prio_nxt = rd_prio;
            hit_pol_nxt  = rd_pol;
          end
          if (cmp.prio_gt && !gt_found_r) begin
            gt_found_nxt = 1'b1;
            ins_idx_nxt  = pend_idx_r;
          end
        end
        // Decide once every stored slot has been compared.
        if (scan_done) begin
          res_status_nxt = ST_MISS;
          res_pos_nxt    = '0;
          res_prio_nxt   = '0;
          res_pol_nxt    = '0;
          state_nxt      = S_DONE;
          priority if (op_r == OP_INSERT) begin
            if (hit_r) begin
              res_status_nxt = ST_DUP;
              res_pos_nxt    = hit_idx_r;
            end else if (cnt_r == CW'(DEPTH)) begin
              res_status_nxt = ST_FULL;
            end else if (gt_found_r) begin
              rd_idx_nxt   = cnt_r - CW'(1);
              iss_done_nxt = 1'b0;
              state_nxt    = S_SHUP;
            end else begin
              ins_idx_nxt = cnt_r[IW-1:0];
              state_nxt   = S_PUT;
            end
          end else if ((op_r == OP_DELETE || op_r == OP_LOOKUP) && hit_r) begin
            res_status_nxt = ST_OK;
            res_pos_nxt    = hit_idx_r;
            res_prio_nxt   = hit_prio_r;
            res_pol_nxt    = hit_pol_r;
            if (op_r == OP_DELETE) begin
              if (del_src < cnt_r) begin
                rd_idx_nxt   = del_src;
                iss_done_nxt = 1'b0;
                state_nxt    = S_SHDN;
              end else begin
                cnt_nxt = cnt_r - CW'(1);
              end
            end
          end else begin
            res_status_nxt = ST_MISS;
          end
        end
      end

      S_SHUP: begin
        // Move entries one slot up, from the top down to the insertion slot.
        if (!iss_done_r) begin
          rd_pend_nxt  = 1'b1;
          pend_idx_nxt = rd_idx_r[IW-1:0];
          if (rd_idx_r == CW'(ins_idx_r)) begin
            iss_done_nxt = 1'b1;
          end else begin
            rd_idx_nxt = rd_idx_r - CW'(1);
          end
        end
        if (rd_pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pend_idx_r + IW'(1);
          mem_wdata = mem_rdata;
        end
        if (iss_done_r && !rd_pend_r) begin
          state_nxt = S_PUT;
        end
      end

      S_SHDN: begin
        // Move entries one slot down, closing the gap left by the removed entry.
        if (!iss_done_r) begin
          rd_pend_nxt  = 1'b1;
          pend_idx_nxt = rd_idx_r[IW-1:0];
          if (rd_idx_r == cnt_r - CW'(1)) begin
            iss_done_nxt = 1'b1;
          end else begin
            rd_idx_nxt = rd_idx_r + CW'(1);
          end
        end
        if (rd_pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pend_idx_r - IW'(1);
          mem_wdata = mem_rdata;
        end
        if (iss_done_r && !rd_pend_r) begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_PUT: begin
        // Write the new entry into the freed slot.
        mem_we         = 1'b1;
        mem_waddr      = ins_idx_r;
        mem_wdata      = {tag_r, prio_r, key_r};
        cnt_nxt        = cnt_r + CW'(1);
        res_status_nxt = ST_OK;
        res_pos_nxt    = ins_idx_r;
        res_prio_nxt   = '0;
        res_pol_nxt    = '0;
        state_nxt      = S_DONE;
      end

      S_DONE: begin
        // Load the result once the output register is free.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = res_status_r;
          out_data_nxt  = {
            (OUT_TDATA_W - POS_W - PRIO_W - POLICY_W - COUNT_W)'(0),
            COUNT_W'(cnt_r),
            res_pol_r,
            PRIO_W'(res_prio_r),
            POS_W'(res_pos_r)
          };
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, control and payload registers; reset clears control only, and not pend_idx_r.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      rd_idx_r    <= '0;
      rd_pend_r   <= 1'b0;
      iss_done_r  <= 1'b0;
      hit_r       <= 1'b0;
      gt_found_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      rd_idx_r    <= rd_idx_nxt;
      rd_pend_r   <= rd_pend_nxt;
      iss_done_r  <= iss_done_nxt;
      hit_r       <= hit_nxt;
      gt_found_r  <= gt_found_nxt;
    end
    pend_idx_r   <= pend_idx_nxt;
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    prio_r       <= prio_nxt;
    tag_r        <= tag_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_prio_r   <= hit_prio_nxt;
    hit_pol_r    <= hit_pol_nxt;
    ins_idx_r    <= ins_idx_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    res_prio_r   <= res_prio_nxt;
    res_pol_r    <= res_pol_nxt;
    out_data_r   <= out_data_nxt;
    out_user_r   <= out_user_nxt;
  end

  // The entry count never passes the table depth.
  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count beyond table depth");

  // The memory is written only during shift and placement steps.
  a_we_state : assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_SHUP || state_r == S_SHDN || state_r == S_PUT))
    else $error("memory write outside a write step");

  // Placing a new entry raises the count by exactly one.
  a_put_count : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUT) |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("insert did not raise the entry count");

  // An accepted item always starts a scan; items are taken only in the idle state.
  a_accept_idle : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_SCAN))
    else $error("accepted item did not start a scan");

endmodule

// ----- dv/priority_sorted_keyed_table_test.sv -----
// Self-checking testbench of the priority-sorted keyed table, with its scoreboard.
module priority_sorted_keyed_table_test;
  import pstk_pkg::*;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned MAX_REPORTS = 50;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  // Fields of one result item as the table should return it.
  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [PRIO_W-1:0]   found_prio;
    logic [POLICY_W-1:0] found_policy;
    logic [COUNT_W-1:0]  count;
  } reply_t;

  typedef enum {FILL_BURST, DRAIN_BURST, MIXED_BURST} burst_t;

  // Keeps its own copy of the table and the results still owed by the block.
  class slot_table_checker;
    logic [KEY_W-1:0]    slot_key    [TABLE_DEPTH];
    logic [PRIO_W-1:0]   slot_prio   [TABLE_DEPTH];
    logic [POLICY_W-1:0] slot_policy [TABLE_DEPTH];
    int unsigned entries;
    reply_t replies_due [$];
    int unsigned mismatches, requests, placed, dups, fulls, hits, misses, spares, peak;

    function int unsigned pending();
      return replies_due.size();
    endfunction

    // Applies one accepted item to the table copy and queues the reply it must cause.
    function void note_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                               input logic [PRIO_W-1:0] prio,
                               input logic [POLICY_W-1:0] tag);
      reply_t r;
      bit hit;
      int unsigned at;
      int unsigned i;
      r.status = ST_MISS;
      r.position = '0;
      r.found_prio = '0;
      r.found_policy = '0;
      hit = 1'b0;
      at = 0;
      requests++;
      // The key is searched over every valid slot, whatever the operation.
      for (i = 0; i < entries; i++) begin
        if (!hit && slot_key[i] == key) begin
          hit = 1'b1;
          at = i;
        end
      end
      if (op == OP_INSERT) begin
        if (hit) begin
          r.status = ST_DUP;
          r.position = POS_W'(at);
          dups++;
        end else if (entries >= TABLE_DEPTH) begin
          r.status = ST_FULL;
          fulls++;
        end else begin
          // New entry goes before the first strictly greater priority.
          at = entries;
          for (i = entries; i > 0; i--) begin
            if (slot_prio[i-1] > prio) at = i - 1;
          end
          for (i = entries; i > at; i--) begin
            slot_key[i] = slot_key[i-1];
            slot_prio[i] = slot_prio[i-1];
            slot_policy[i] = slot_policy[i-1];
          end
          slot_key[at] = key;
          slot_prio[at] = prio;
          slot_policy[at] = tag;
          entries++;
          if (entries > peak) peak = entries;
          r.status = ST_OK;
          r.position = POS_W'(at);
          placed++;
        end
      end else if ((op == OP_DELETE || op == OP_LOOKUP) && hit) begin
        r.status = ST_OK;
        r.position = POS_W'(at);
        r.found_prio = slot_prio[at];
        r.found_policy = slot_policy[at];
        hits++;
        // A delete closes the gap behind the removed entry.
        if (op == OP_DELETE) begin
          for (i = at; i + 1 < entries; i++) begin
            slot_key[i] = slot_key[i+1];
            slot_prio[i] = slot_prio[i+1];
            slot_policy[i] = slot_policy[i+1];
          end
          entries--;
        end
      end else if (op == OP_SPARE) begin
        spares++;
      end else begin
        misses++;
      end
      r.count = COUNT_W'(entries);
      replies_due.push_back(r);
    endfunction

    function void compare(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // Compares one accepted result with the oldest reply still owed.
    function void check_reply(input logic [STATUS_W-1:0] status,
                              input logic [OUT_TDATA_W-1:0] data);
      reply_t want;
      if (replies_due.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: result with none outstanding: expected nothing, actual status %0h data %h",
                   $time, status, data);
        mismatches++;
        return;
      end
      want = replies_due.pop_front();
      compare("status", 32'(want.status), 32'(status));
      compare("position", 32'(want.position), 32'(data[3:0]));
      compare("found_prio", 32'(want.found_prio), 32'(data[19:4]));
      compare("found_policy", 32'(want.found_policy), 32'(data[27:20]));
      compare("count", 32'(want.count), 32'(data[32:28]));
      compare("padding", 32'd0, 32'(data[39:33]));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [OP_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0] out_tuser;

  bit tx_no_idle = 1'b0;
  bit rx_no_idle = 1'b0;
  int unsigned cycles = 0;
  slot_table_checker sb = new();

  priority_sorted_keyed_table #(
    .DEPTH(TABLE_DEPTH),
    .KEY_BITS(KEY_W),
    .PRIO_BITS(PRIO_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Guards against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, sb.pending());
      $display("priority_sorted_keyed_table test failed");
      $finish;
    end
  end

  // Presents one item, waits for it to be taken, then idles for a random gap.
  // The valid stays high when the next item follows at once.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                           input logic [PRIO_W-1:0] prio, input logic [POLICY_W-1:0] tag);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tdata <= {tag, prio, key};
    in_tuser <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(op, key, prio, tag);
    gap = tx_no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds off the sender until every owed result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Result side: random stall before each item, then check what arrives.
  initial begin
    int unsigned stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = rx_no_idle ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.check_reply(out_tuser, out_tdata);
    end
  end

  // Stimulus: directed corner cases first, then random bursts.
  initial begin
    burst_t mode;
    int unsigned b, n, roll, ins_pct, del_pct;
    logic [OP_W-1:0] op;
    logic [KEY_W-1:0] key;
    logic [PRIO_W-1:0] prio;
    logic [POLICY_W-1:0] tag;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extremes of every field, ties in priority, duplicates and misses.
    send_item(OP_INSERT, 8'd0, 16'hFFFF, 8'hFF);
    send_item(OP_INSERT, 8'd255, 16'h0000, 8'h00);
    send_item(OP_INSERT, 8'd128, 16'h0000, 8'hAA);   // equal priority lands behind
    send_item(OP_INSERT, 8'd0, 16'h0005, 8'h55);     // key already held
    send_item(OP_LOOKUP, 8'd255, 16'h1234, 8'h12);
    send_item(OP_LOOKUP, 8'd1, 16'h0000, 8'h00);
    send_item(OP_LOOKUP, 8'd128, 16'hFFFF, 8'hFF);
    send_item(OP_DELETE, 8'd128, 16'h0000, 8'h00);   // middle slot
    send_item(OP_DELETE, 8'd128, 16'h0000, 8'h00);   // now absent
    send_item(OP_SPARE, 8'd0, 16'hFFFF, 8'hFF);      // unused opcode on a held key
    send_item(OP_DELETE, 8'd0, 16'h0000, 8'h00);     // last slot
    send_item(OP_DELETE, 8'd255, 16'h0000, 8'h00);   // table empties
    send_item(OP_DELETE, 8'd255, 16'h0000, 8'h00);
    send_item(OP_LOOKUP, 8'd0, 16'h0000, 8'h00);

    // Bursts lean towards filling, draining or a mix; the first one is a filling burst.
    for (b = 0; b < 19; b++) begin
      mode = (b == 0) ? FILL_BURST : burst_t'($urandom_range(0, 2));
      tx_no_idle = ($urandom_range(0, 3) == 0);
      rx_no_idle = ($urandom_range(0, 3) == 0);
      if (b == 0 || b == 10) drain_results();
      ins_pct = (mode == FILL_BURST) ? 70 : (mode == DRAIN_BURST) ? 20 : 40;
      del_pct = (mode == FILL_BURST) ? 80 : (mode == DRAIN_BURST) ? 75 : 70;
      for (n = 0; n < 50; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < ins_pct) op = OP_INSERT;
        else if (roll < del_pct) op = OP_DELETE;
        else if (roll < 97) op = OP_LOOKUP;
        else op = OP_SPARE;
        // Mostly keys that are held or from a small pool, so hits and duplicates are common.
        roll = $urandom_range(0, 99);
        if (sb.entries > 0 && roll < ((op == OP_INSERT) ? 10 : 75))
          key = sb.slot_key[$urandom_range(0, sb.entries - 1)];
        else if (roll < 85)
          key = KEY_W'($urandom_range(0, 23));
        else
          key = KEY_W'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
          0: prio = PRIO_W'($urandom_range(0, 3));
          1: prio = ($urandom_range(0, 1) != 0) ? '1 : '0;
          default: prio = PRIO_W'($urandom_range(0, 65535));
        endcase
        tag = POLICY_W'($urandom_range(0, 255));
        send_item(op, key, prio, tag);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d items: %0d inserts placed, %0d duplicate keys, %0d inserts on a full table.",
             sb.requests, sb.placed, sb.dups, sb.fulls);
    $display("Deletes and lookups: %0d hits, %0d misses; %0d unused opcodes; peak fill %0d.",
             sb.hits, sb.misses, sb.spares, sb.peak);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("priority_sorted_keyed_table test passed");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.mismatches, sb.pending());
      $display("priority_sorted_keyed_table test failed");
    end
    $finish;
  end

endmodule
